### hw/rtl/stunbr_pkg.sv
// Package for the STUN binding response parser: protocol constants, status codes
// and the default datagram limit. It has no dependencies of its own and is
// imported by the parser core.
package stunbr_pkg;

  localparam int MAX_DATAGRAM_DEF = 1024;

  localparam logic [31:0] STUN_COOKIE      = 32'h2112A442;
  localparam logic [15:0] TYPE_BIND_RESP   = 16'h0101;
  localparam logic [15:0] TYPE_BIND_ERR    = 16'h0111;
  localparam logic [15:0] ATTR_XOR_MAPPED  = 16'h0020;
  localparam logic [15:0] ATTR_MAPPED      = 16'h0001;
  localparam logic [7:0]  FAMILY_IPV4      = 8'h01;

  // Header length in bytes, and the width of the attribute position counters.
  localparam int HDR_LEN  = 20;
  localparam int ATTR_W   = 18;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_COOKIE= 3'd2,
    ST_TXID_BAD  = 3'd3,
    ST_ERR_RESP  = 3'd4,
    ST_BAD_TYPE  = 3'd5,
    ST_NO_ADDR   = 3'd6
  } status_t;

  // Register byte addresses on the configuration port.
  localparam logic [3:0] REG_TXID_HIGH = 4'h0;
  localparam logic [3:0] REG_TXID_LOW  = 4'h8;

endpackage

### hw/rtl/stun_binding_response_parser_core.sv
// STUN binding response parser core: byte stream in, one status/address word per
// datagram out, with an APB-style port for the expected transaction ID.
// Depends on stunbr_pkg.
//
//   channel | dir | handshake                        | payload
//   in_     | in  | in_tvalid / in_tready            | in_tdata = rx_byte, in_tlast = last_byte
//   out_    | out | out_tvalid / out_tready          | out_tdata = address, port; out_tuser = status
//   cfg_    | in  | cfg_psel, cfg_penable, cfg_pready| cfg_pwdata / cfg_prdata, 64 bits
//
// One byte is accepted per clock. A byte is held in the input register and is folded into
// the parse state as it leaves; the result word for a datagram is loaded into the output
// register at that same edge, so out_tvalid rises as the final byte leaves
// the input register. rst_n is synchronous and clears the parse state, the valid flags and
// the configuration registers. The input side stalls only when a final byte is waiting and
// the output register is still full.
module stun_binding_response_parser_core #(
  parameter int MAX_DATAGRAM = stunbr_pkg::MAX_DATAGRAM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [31:0] ipv4_address, [47:32] udp_port
  output logic [2:0]  out_tuser,   // [2:0] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  import stunbr_pkg::*;

  localparam int PosW = $clog2(MAX_DATAGRAM + 1);

  // Configuration.
  logic [31:0] txid_high_r;
  logic [63:0] txid_low_r;

  // Input register.
  logic       v1_r;
  logic [7:0] b1_r;
  logic       last1_r;

  // Parse state.
  logic [PosW-1:0]   pos_r, pos_upd, pos_nxt;
  logic [15:0]       mtype_r, mtype_upd, mtype_nxt;
  logic [15:0]       mlen_r, mlen_upd, mlen_nxt;
  logic              cookie_ok_r, cookie_ok_upd, cookie_ok_nxt;
  logic              txid_ok_r, txid_ok_upd, txid_ok_nxt;
  logic [ATTR_W-1:0] nas_r, nas_upd, nas_nxt;
  logic [15:0]       atype_r, atype_upd, atype_nxt;
  logic [15:0]       alen_r, alen_upd, alen_nxt;
  logic [7:0]        fam_r, fam_upd, fam_nxt;
  logic              found_r, found_upd, found_nxt;
  logic [31:0]       addr_r, addr_upd, addr_nxt;
  logic [15:0]       port_r, port_upd, port_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r;
  logic [31:0] out_addr_r;
  logic [15:0] out_port_r;

  logic        advance;
  logic        in_range;
  logic [ATTR_W-1:0] pos_ext, rel, attr_end;
  logic [16:0] padded;
  logic        walk_on, cand;
  logic [3:0]  tx_idx;
  logic [7:0]  cookie_byte, txid_byte;
  logic [95:0] txid_all;
  status_t     status;

  assign advance   = v1_r && (!last1_r || !out_valid_r || out_tready);
  assign in_tready = !v1_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_tready) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      b1_r    <= in_tdata;
      last1_r <= in_tlast;
    end
  end

  assign txid_all    = {txid_high_r, txid_low_r};
  assign in_range    = pos_r < PosW'(MAX_DATAGRAM);
  assign pos_ext     = ATTR_W'(pos_r);
  assign tx_idx      = 4'(pos_r - PosW'(8));
  assign cookie_byte = 8'(STUN_COOKIE >> {~pos_r[1:0], 3'b000});
  assign txid_byte   = 8'(txid_all >> {4'd11 - tx_idx, 3'b000});
  assign attr_end    = ATTR_W'(mlen_r) + ATTR_W'(HDR_LEN);
  assign walk_on     = !found_r && (nas_r < attr_end) && (pos_ext >= nas_r);
  assign rel         = pos_ext - nas_r;

  always_comb begin
    pos_upd       = pos_r;
    mtype_upd     = mtype_r;
    mlen_upd      = mlen_r;
    cookie_ok_upd = cookie_ok_r;
    txid_ok_upd   = txid_ok_r;
    nas_upd       = nas_r;
    atype_upd     = atype_r;
    alen_upd      = alen_r;
    fam_upd       = fam_r;
    found_upd     = found_r;
    addr_upd      = addr_r;
    port_upd      = port_r;
    cand          = 1'b0;
    padded        = '0;
    if (in_range) begin
      pos_upd = pos_r + PosW'(1);
      if (pos_r < PosW'(2)) begin
        mtype_upd = {mtype_r[7:0], b1_r};
      end else if (pos_r < PosW'(4)) begin
        mlen_upd = {mlen_r[7:0], b1_r};
      end else if (pos_r < PosW'(8)) begin
        if (b1_r != cookie_byte) cookie_ok_upd = 1'b0;
      end else if (pos_r < PosW'(HDR_LEN)) begin
        if (b1_r != txid_byte) txid_ok_upd = 1'b0;
      end else if (walk_on) begin
        if (rel == ATTR_W'(0)) atype_upd = {b1_r, 8'h00};
        else if (rel == ATTR_W'(1)) atype_upd = atype_r | {8'h00, b1_r};
        else if (rel == ATTR_W'(2)) alen_upd = {b1_r, 8'h00};
        else if (rel == ATTR_W'(3)) alen_upd = alen_r | {8'h00, b1_r};
        else if (rel == ATTR_W'(5)) fam_upd = b1_r;
        else if (rel == ATTR_W'(6)) port_upd = {b1_r, 8'h00};
        else if (rel == ATTR_W'(7)) port_upd = port_r | {8'h00, b1_r};
        else if (rel >= ATTR_W'(8) && rel <= ATTR_W'(11)) addr_upd = {addr_r[23:0], b1_r};

        if (rel >= ATTR_W'(3)) begin
          cand = (atype_upd == ATTR_XOR_MAPPED || atype_upd == ATTR_MAPPED) &&
                 alen_upd >= 16'd8 && fam_upd == FAMILY_IPV4;
          padded = ({1'b0, alen_upd} + 17'd3) & ~17'd3;
          if (cand && rel == ATTR_W'(alen_upd) + ATTR_W'(3)) begin
            found_upd = 1'b1;
            if (atype_upd == ATTR_XOR_MAPPED) begin
              addr_upd = addr_upd ^ STUN_COOKIE;
              port_upd = port_upd ^ STUN_COOKIE[31:16];
            end
          end else if (rel == ATTR_W'(padded) + ATTR_W'(3)) begin
            // Padded end of this attribute: the next one starts on the following byte.
            nas_upd = nas_r + ATTR_W'(4) + ATTR_W'(padded);
            fam_upd = '0;
          end
        end
      end
    end
  end

  always_comb begin
    if (pos_upd < PosW'(HDR_LEN))        status = ST_SHORT;
    else if (!cookie_ok_upd)             status = ST_BAD_COOKIE;
    else if (!txid_ok_upd)               status = ST_TXID_BAD;
    else if (mtype_upd == TYPE_BIND_ERR) status = ST_ERR_RESP;
    else if (mtype_upd != TYPE_BIND_RESP) status = ST_BAD_TYPE;
    else if (!found_upd)                 status = ST_NO_ADDR;
    else                                 status = ST_OK;
  end

  always_comb begin
    pos_nxt       = pos_r;
    mtype_nxt     = mtype_r;
    mlen_nxt      = mlen_r;
    cookie_ok_nxt = cookie_ok_r;
    txid_ok_nxt   = txid_ok_r;
    nas_nxt       = nas_r;
    atype_nxt     = atype_r;
    alen_nxt      = alen_r;
    fam_nxt       = fam_r;
    found_nxt     = found_r;
    addr_nxt      = addr_r;
    port_nxt      = port_r;
    if (advance) begin
      if (last1_r) begin
        // The datagram is finished, so the parse state starts afresh.
        pos_nxt       = '0;
        mtype_nxt     = '0;
        mlen_nxt      = '0;
        cookie_ok_nxt = 1'b1;
        txid_ok_nxt   = 1'b1;
        nas_nxt       = ATTR_W'(HDR_LEN);
        atype_nxt     = '0;
        alen_nxt      = '0;
        fam_nxt       = '0;
        found_nxt     = 1'b0;
        addr_nxt      = '0;
        port_nxt      = '0;
      end else begin
        pos_nxt       = pos_upd;
        mtype_nxt     = mtype_upd;
        mlen_nxt      = mlen_upd;
        cookie_ok_nxt = cookie_ok_upd;
        txid_ok_nxt   = txid_ok_upd;
        nas_nxt       = nas_upd;
        atype_nxt     = atype_upd;
        alen_nxt      = alen_upd;
        fam_nxt       = fam_upd;
        found_nxt     = found_upd;
        addr_nxt      = addr_upd;
        port_nxt      = port_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      mtype_r     <= '0;
      mlen_r      <= '0;
      cookie_ok_r <= 1'b1;
      txid_ok_r   <= 1'b1;
      nas_r       <= ATTR_W'(HDR_LEN);
      atype_r     <= '0;
      alen_r      <= '0;
      fam_r       <= '0;
      found_r     <= 1'b0;
      addr_r      <= '0;
      port_r      <= '0;
    end else begin
      pos_r       <= pos_nxt;
      mtype_r     <= mtype_nxt;
      mlen_r      <= mlen_nxt;
      cookie_ok_r <= cookie_ok_nxt;
      txid_ok_r   <= txid_ok_nxt;
      nas_r       <= nas_nxt;
      atype_r     <= atype_nxt;
      alen_r      <= alen_nxt;
      fam_r       <= fam_nxt;
      found_r     <= found_nxt;
      addr_r      <= addr_nxt;
      port_r      <= port_nxt;
    end
  end

  assign out_valid_nxt = (out_valid_r && !out_tready) || (advance && last1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last1_r) begin
      out_status_r <= status;
      out_addr_r   <= (status == ST_OK) ? addr_upd : '0;
      out_port_r   <= (status == ST_OK) ? port_upd : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_port_r, out_addr_r};
  assign out_tuser  = out_status_r;

  // Only bit 3 of the address selects the register on writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      txid_high_r <= '0;
      txid_low_r  <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[3]) txid_low_r <= cfg_pwdata;
      else              txid_high_r <= cfg_pwdata[31:0];
    end
  end

  always_comb begin
    case (cfg_paddr)
      REG_TXID_HIGH: cfg_prdata = {32'h0, txid_high_r};
      REG_TXID_LOW:  cfg_prdata = txid_low_r;
      default:       cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;

endmodule
